FILE: hdl/signed_int_to_radix_ascii_defines.svh
// Assertion macros for the top-level RTL file.
`ifndef SIGNED_INT_TO_RADIX_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_ASCII_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset.
`define SITRA_ASSERT(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define SITRA_ASSERT_ALWAYS(name, clock, prop, msg) \
  name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define SITRA_ASSERT(name, clock, reset, prop, msg)
`define SITRA_ASSERT_ALWAYS(name, clock, prop, msg)

`endif

`endif

FILE: hdl/sitra_pkg.sv
`default_nettype none

package sitra_pkg;

  localparam int DIGIT_W = 6;

  localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;

  localparam logic [7:0] CHAR_ZERO     = 8'h30;  // '0'
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;  // '-'
  localparam logic [7:0] LETTER_OFFSET = 8'd87;  // 10 -> 'a'

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_READ = 5'b01000,
    ST_LOAD = 5'b10000
  } state_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] wide;
    wide = {2'b00, d};
    if (d >= DECIMAL_LIMIT) begin
      return wide + LETTER_OFFSET;
    end
    return wide + CHAR_ZERO;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/signed_int_to_radix_ascii.sv
// Converts one signed VALUE_BITS-bit integer per input beat into its ASCII
// text in the base held in the radix register (2..36; 0 and 1 act as 2, 37
// and up act as 36; reset value 10). Output beats carry one character each,
// most significant first, with '-' ahead of a negative value and 'a'..'z'
// for digits 10..35; tlast marks the final character. The most negative
// value converts as magnitude 2^(VALUE_BITS-1). Digits come from a shared
// bit-serial divider; then the '-' goes out, if any, and each digit is
// read back from the digit RAM. The input is not ready until the last
// character has been loaded into the output register, where it may still
// wait when the next value is taken. Write the radix only while idle.
`default_nettype none

`include "signed_int_to_radix_ascii_defines.svh"

module signed_int_to_radix_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wen,
  input  wire logic [sitra_pkg::DIGIT_W-1:0]         cfg_wdata,   // radix
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]       s_tdata,     // value
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic      [7:0]                            m_tdata,     // character
  output logic                                       m_tlast      // last_char
);

  localparam int DW   = sitra_pkg::DIGIT_W;
  localparam int AW   = $clog2(VALUE_BITS);
  localparam int CNTW = $clog2(VALUE_BITS + 1);

  sitra_pkg::state_t state, state_next;

  logic [DW-1:0]         radix;
  logic [DW-1:0]         radix_eff;
  logic                  accept;
  logic [VALUE_BITS-1:0] value_in;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic                  neg;
  logic [CNTW-1:0]       cnt;
  logic [CNTW-1:0]       cnt_m1;
  logic                  out_free;
  logic                  last_load;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quo;
  logic [DW-1:0]         div_rem;
  logic                  div_done;
  logic                  div_last;
  logic [DW-1:0]         ram_rdata;

  always_comb begin
    if (radix < sitra_pkg::RADIX_MIN) begin
      radix_eff = sitra_pkg::RADIX_MIN;
    end else if (radix > sitra_pkg::RADIX_MAX) begin
      radix_eff = sitra_pkg::RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  assign s_tready = (state == sitra_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign value_in = s_tdata[VALUE_BITS-1:0];
  assign neg_in   = value_in[VALUE_BITS-1];
  assign mag_in   = neg_in ? (~value_in + VALUE_BITS'(1)) : value_in;
  assign out_free = !m_tvalid || m_tready;
  assign cnt_m1   = cnt - CNTW'(1);
  assign last_load = (state == sitra_pkg::ST_LOAD) && out_free && (cnt == CNTW'(1));

  // Stop on a zero quotient or when the store is full.
  assign div_last     = (div_quo == '0) || (cnt == CNTW'(VALUE_BITS - 1));
  assign div_start    = accept || (div_done && !div_last);
  assign div_dividend = accept ? mag_in : div_quo;

  sitra_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix_eff),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  sitra_ram #(
    .WIDTH(DW),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk   (clk),
    .we    (div_done),
    .waddr (cnt[AW-1:0]),
    .wdata (div_rem),
    .re    (state == sitra_pkg::ST_READ),
    .raddr (cnt_m1[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      sitra_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = sitra_pkg::ST_DIV;
        end
      end
      sitra_pkg::ST_DIV: begin
        if (div_done && div_last) begin
          state_next = neg ? sitra_pkg::ST_SIGN : sitra_pkg::ST_READ;
        end
      end
      sitra_pkg::ST_SIGN: begin
        if (out_free) begin
          state_next = sitra_pkg::ST_READ;
        end
      end
      sitra_pkg::ST_READ: begin
        state_next = sitra_pkg::ST_LOAD;
      end
      sitra_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = (cnt == CNTW'(1)) ? sitra_pkg::ST_IDLE : sitra_pkg::ST_READ;
        end
      end
      default: begin
        state_next = sitra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sitra_pkg::ST_IDLE;
      radix    <= sitra_pkg::RADIX_RESET;
      cnt      <= '0;
      neg      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        radix <= cfg_wdata;
      end
      if (accept) begin
        cnt <= '0;
        neg <= neg_in;
      end else if (div_done) begin
        cnt <= cnt + CNTW'(1);
      end else if (state == sitra_pkg::ST_LOAD && out_free) begin
        cnt <= cnt_m1;
      end
      if ((state == sitra_pkg::ST_SIGN || state == sitra_pkg::ST_LOAD) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sitra_pkg::ST_SIGN && out_free) begin
      m_tdata <= sitra_pkg::CHAR_MINUS;
      m_tlast <= 1'b0;
    end else if (state == sitra_pkg::ST_LOAD && out_free) begin
      m_tdata <= sitra_pkg::digit_char(ram_rdata);
      m_tlast <= (cnt == CNTW'(1));
    end
  end

  `SITRA_ASSERT(a_done_in_div, clk, rst, div_done |-> state == sitra_pkg::ST_DIV, "stray done")
  `SITRA_ASSERT(a_rem_below_radix, clk, rst, div_done |-> div_rem < radix_eff, "digit >= radix")
  `SITRA_ASSERT(a_cnt_bound, clk, rst, cnt <= CNTW'(VALUE_BITS), "count past depth")
  `SITRA_ASSERT(a_last_to_idle, clk, rst, last_load |=> s_tready && m_tvalid && m_tlast, "bad end")

endmodule

`default_nettype wire

FILE: hdl/sitra_ram.sv
`default_nettype none

module sitra_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sitra_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The remainder stays below
// the divisor, so it fits the digit width.
module sitra_div #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [VALUE_BITS-1:0]          dividend,
  input  wire logic [sitra_pkg::DIGIT_W-1:0]  divisor,
  output logic      [VALUE_BITS-1:0]          quotient,
  output logic      [sitra_pkg::DIGIT_W-1:0]  remainder,
  output logic                                done
);

  localparam int DW = sitra_pkg::DIGIT_W;
  localparam int CW = $clog2(VALUE_BITS);

  logic          busy;
  logic [CW-1:0] step;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_next;

  assign trial    = {remainder, quotient[VALUE_BITS-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= CW'(VALUE_BITS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[VALUE_BITS-2:0], ge};
      remainder <= rem_next;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/signed_int_to_radix_ascii_tb.sv
`timescale 1ns / 100ps

module signed_int_to_radix_ascii_tb;

  localparam int DW = sitra_pkg::DIGIT_W;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } text_beat_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [DW-1:0]       cfg_wdata = sitra_pkg::RADIX_RESET;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;       // [31:0] value
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;            // [7:0] character
  logic                m_tlast;

  logic [31:0]         pending_values[$];
  text_beat_t          expected_text[$];
  text_beat_t          want;
  logic [DW-1:0]       radix_setting = sitra_pkg::RADIX_RESET;

  bit                  send_quiet = 1'b0;
  bit                  recv_quiet = 1'b0;
  int unsigned         send_gap = 0;
  int unsigned         recv_gap = 0;
  int unsigned         stall_draw;

  int unsigned         mismatches = 0;
  int unsigned         values_sent = 0;
  int unsigned         chars_checked = 0;
  int unsigned         settings_used = 1;
  int unsigned         longest_text = 0;

  signed_int_to_radix_ascii dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // out-of-range register values saturate to the nearest legal base
  function automatic logic [DW-1:0] effective_base(input logic [DW-1:0] r);
    if (r < sitra_pkg::RADIX_MIN) begin
      return sitra_pkg::RADIX_MIN;
    end
    if (r > sitra_pkg::RADIX_MAX) begin
      return sitra_pkg::RADIX_MAX;
    end
    return r;
  endfunction

  function automatic void predict_text(input logic [31:0] value);
    logic [31:0]   magnitude;
    logic [DW-1:0] base;
    logic [DW-1:0] digits[$];
    logic [7:0]    ch;
    base = effective_base(radix_setting);
    // two's complement negate also gives 2^31 for the most negative value
    magnitude = value[31] ? ~value + 32'd1 : value;
    do begin
      digits.push_front(DW'(magnitude % base));
      magnitude = magnitude / base;
    end while (magnitude != 0);
    if (value[31]) begin
      expected_text.push_back('{sitra_pkg::CHAR_MINUS, 1'b0});
    end
    foreach (digits[i]) begin
      ch = (digits[i] < sitra_pkg::DECIMAL_LIMIT) ?
           sitra_pkg::CHAR_ZERO + digits[i] :
           sitra_pkg::LETTER_OFFSET + digits[i];
      expected_text.push_back('{ch, (i == digits.size() - 1)});
    end
    if (digits.size() + value[31] > longest_text) begin
      longest_text = digits.size() + value[31];
    end
  endfunction

  function automatic logic [31:0] pick_value(input logic [DW-1:0] base);
    logic [63:0] w;
    logic [31:0] p;
    case ($urandom_range(0, 5))
      0, 1: begin
        return $urandom;
      end
      2: begin
        return $urandom_range(0, 2000) - 32'd1000;
      end
      3: begin
        case ($urandom_range(0, 5))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hFFFF_FFFF;
          3: return 32'h7FFF_FFFF;
          4: return 32'h8000_0000;
          default: return 32'h8000_0001;
        endcase
      end
      4: begin
        // near a power of the base, where the digit count steps
        w = 64'd1;
        repeat ($urandom_range(1, 31)) begin
          if (w * base <= 64'h8000_0000) begin
            w = w * base;
          end
        end
        w = w + $urandom_range(0, 2) - 1;
        p = w[31:0];
        return $urandom_range(0, 1) ? ~p + 32'd1 : p;
      end
      default: begin
        p = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? ~p + 32'd1 : p;
      end
    endcase
  endfunction

  // checked at the falling edge so the posedge queue updates have settled
  task automatic wait_for_text;
    do @(negedge clk);
    while (pending_values.size() != 0 || s_tvalid || expected_text.size() != 0);
  endtask

  task automatic set_radix(input logic [DW-1:0] r);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_wen <= 1'b0;
    radix_setting = r;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [DW-1:0] r, input int unsigned count);
    logic [DW-1:0] base;
    wait_for_text();
    send_quiet = ($urandom_range(0, 3) == 0);
    recv_quiet = ($urandom_range(0, 3) == 0);
    set_radix(r);
    base = effective_base(r);
    for (int i = 0; i < count; i++) begin
      // hold the sender midway until all text so far is back
      if (i == count / 2) begin
        wait_for_text();
      end
      pending_values.push_back(pick_value(base));
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_text(s_tdata);
        values_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          s_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_values.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_values.pop_front();
          send_gap <= send_quiet ? 0 : $urandom_range(0, 14);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
    end else if (m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character beat 8'h%02h last %0b",
                                  m_tdata, m_tlast));
      end else begin
        want = expected_text.pop_front();
        if (m_tdata !== want.character) begin
          report_mismatch($sformatf("character 8'h%02h, expected 8'h%02h",
                                    m_tdata, want.character));
        end
        if (m_tlast !== want.last_char) begin
          report_mismatch($sformatf("last flag %0b, expected %0b on character 8'h%02h",
                                    m_tlast, want.last_char, want.character));
        end
      end
      chars_checked++;
      stall_draw = recv_quiet ? 0 : $urandom_range(0, 14);
      recv_gap <= stall_draw;
      m_tready <= (stall_draw == 0);
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= (recv_gap == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // decimal out of reset: zero, sign, digit rollover, both extremes
    pending_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd999_999_999,
                       32'hF8A4_32EB, 32'd42};
    wait_for_text();
    set_radix(sitra_pkg::RADIX_MAX);
    pending_values = '{32'd35, 32'd36, 32'hFFFF_FFDD, 32'h7FFF_FFFF, 32'h8000_0000};
    wait_for_text();
    // binary: the most negative value gives the longest string
    set_radix(sitra_pkg::RADIX_MIN);
    pending_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

    run_phase(6'd10, 60);
    run_phase(6'd2, 25);
    run_phase(6'd36, 50);
    run_phase(6'd0, 12);
    run_phase(6'd1, 12);
    run_phase(6'd63, 40);
    run_phase(6'd37, 40);
    run_phase(6'd16, 60);
    run_phase(6'd8, 40);
    repeat (5) begin
      run_phase(6'($urandom_range(0, 63)), 25);
    end

    wait_for_text();
    repeat (64) @(posedge clk);

    $display("Converted %0d values under %0d radix settings, %0d characters checked.",
             values_sent, settings_used, chars_checked);
    $display("Longest string was %0d characters; %0d mismatches.", longest_text, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
